@@ rtl/core/spi_master_shift_engine_defines.svh @@
// Assertion helpers for the checker file.
`ifndef SPI_MASTER_SHIFT_ENGINE_DEFINES_SVH
`define SPI_MASTER_SHIFT_ENGINE_DEFINES_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SPISE_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("spise assertion failed");

// Same, on the block's own clock and reset.
`define SPISE_ASSERT(label, prop) \
  `SPISE_ASSERT_CLK(label, clk_i, rst_ni, prop)

`endif

@@ rtl/core/spise_pkg.sv @@
package spise_pkg;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int WORD_W     = 16;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CPOL         = 3'd0,
    CFG_CPHA         = 3'd1,
    CFG_LSB_FIRST    = 3'd2,
    CFG_HALF_PERIOD  = 3'd3,
    CFG_MISO_PRESENT = 3'd4
  } cfg_idx_e;

  // Word bit addressed by the current position; high byte goes first on wide words.
  function automatic logic [3:0] bit_idx(logic lsb, logic wide, logic [4:0] bits);
    logic [4:0] total;
    logic [4:0] pos;
    logic [2:0] inbyte;
    total = wide ? 5'd16 : 5'd8;
    if (bits > total || bits == 5'd0) begin
      pos = 5'd0;
    end else begin
      pos = total - bits;
    end
    inbyte = lsb ? pos[2:0] : 3'd7 - pos[2:0];
    return (wide && pos < 5'd8) ? {1'b1, inbyte} : {1'b0, inbyte};
  endfunction

endpackage

@@ rtl/core/spi_master_shift_engine.sv @@
// channel   dir  handshake               payload
// in        in   in_valid_i/in_ready_o   req_type, tx_data, sixteen_bits, miso_level
// out       out  out_valid_o/out_ready_i sck_level, mosi_level, busy_res, done_res, rx_data
// cfg       in   cfg_we_i (no wait)      cfg_idx_i, cfg_data_i
//
// One item per cycle while the output is not stalled: the shift state updates on the
// accepting edge, and on that same edge the result is registered into a single output register.
// in_ready_o is high while the output register is empty or being drained.
// Reset clears the shift state and empties the output register; config takes its reset values.
// A stalled output holds its item and stops intake only for as long as it stalls.
module spi_master_shift_engine #(
  parameter int HALF_PERIOD_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [spise_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [spise_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               req_type_i,
  input  logic [spise_pkg::WORD_W-1:0]       tx_data_i,
  input  logic                               sixteen_bits_i,
  input  logic                               miso_level_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               sck_level_o,
  output logic                               mosi_level_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [spise_pkg::WORD_W-1:0]       rx_data_o
);

  // half period register is at most 16 bits, cut further by HALF_PERIOD_BITS
  localparam int HP_W = (HALF_PERIOD_BITS < 16) ? HALF_PERIOD_BITS : 16;

  logic            cpol_q, cpha_q, lsb_q, miso_pres_q;
  logic [HP_W-1:0] hp_q;

  logic [15:0]     tx_q, tx_d;
  logic [15:0]     rx_q, rx_d;
  logic [4:0]      bits_q, bits_d;
  logic [HP_W-1:0] phase_q, phase_d;
  logic            second_q, second_d;
  logic            active_q, active_d;
  logic            wide_q, wide_d;
  logic            sck_q, sck_d;
  logic            mosi_q, mosi_d;

  logic            out_valid_q;
  logic            sck_out_q, mosi_out_q, busy_out_q, done_out_q;
  logic [15:0]     rx_out_q;

  logic            accept;
  logic            done;
  logic [15:0]     rx_res;
  logic [HP_W:0]   len;
  logic [HP_W:0]   ph_inc;
  logic [4:0]      bits_dec;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpol_q      <= 1'b0;
      cpha_q      <= 1'b0;
      lsb_q       <= 1'b0;
      hp_q        <= '0;
      miso_pres_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        spise_pkg::CFG_CPOL:         cpol_q      <= cfg_data_i[0];
        spise_pkg::CFG_CPHA:         cpha_q      <= cfg_data_i[0];
        spise_pkg::CFG_LSB_FIRST:    lsb_q       <= cfg_data_i[0];
        spise_pkg::CFG_HALF_PERIOD:  hp_q        <= cfg_data_i[HP_W-1:0];
        spise_pkg::CFG_MISO_PRESENT: miso_pres_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign len      = (hp_q == '0) ? {{HP_W{1'b0}}, 1'b1} : {1'b0, hp_q};
  assign ph_inc   = {1'b0, phase_q} + {{HP_W{1'b0}}, 1'b1};
  assign bits_dec = bits_q - 5'd1;

  always_comb begin
    tx_d     = tx_q;
    rx_d     = rx_q;
    bits_d   = bits_q;
    phase_d  = phase_q;
    second_d = second_q;
    active_d = active_q;
    wide_d   = wide_q;
    sck_d    = sck_q;
    mosi_d   = mosi_q;
    done     = 1'b0;
    rx_res   = '0;
    if (accept) begin
      if (req_type_i == spise_pkg::REQ_START) begin
        // a start while busy is dropped
        if (!active_q) begin
          wide_d   = sixteen_bits_i;
          tx_d     = sixteen_bits_i ? tx_data_i : {8'h00, tx_data_i[7:0]};
          rx_d     = '0;
          bits_d   = sixteen_bits_i ? 5'd16 : 5'd8;
          active_d = 1'b1;
          mosi_d   = tx_d[spise_pkg::bit_idx(lsb_q, sixteen_bits_i, bits_d)];
          sck_d    = cpha_q ? ~cpol_q : cpol_q;
          second_d = 1'b0;
          phase_d  = '0;
        end
      end else if (active_q) begin
        if (ph_inc >= len) begin
          phase_d = '0;
          if (!second_q) begin
            second_d = 1'b1;
            sck_d    = ~sck_q;
            if (miso_pres_q && miso_level_i) begin
              rx_d[spise_pkg::bit_idx(lsb_q, wide_q, bits_q)] = 1'b1;
            end
          end else if (bits_dec == 5'd0 || bits_dec > 5'd16) begin
            bits_d   = '0;
            active_d = 1'b0;
            second_d = 1'b0;
            sck_d    = cpol_q;
            done     = 1'b1;
            rx_res   = rx_q;
          end else begin
            bits_d   = bits_dec;
            mosi_d   = tx_q[spise_pkg::bit_idx(lsb_q, wide_q, bits_dec)];
            sck_d    = cpha_q ? ~cpol_q : cpol_q;
            second_d = 1'b0;
          end
        end else begin
          phase_d = ph_inc[HP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q     <= '0;
      rx_q     <= '0;
      bits_q   <= '0;
      phase_q  <= '0;
      second_q <= 1'b0;
      active_q <= 1'b0;
      wide_q   <= 1'b0;
      sck_q    <= 1'b0;
      mosi_q   <= 1'b0;
    end else begin
      tx_q     <= tx_d;
      rx_q     <= rx_d;
      bits_q   <= bits_d;
      phase_q  <= phase_d;
      second_q <= second_d;
      active_q <= active_d;
      wide_q   <= wide_d;
      sck_q    <= sck_d;
      mosi_q   <= mosi_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sck_out_q  <= active_d ? sck_d : cpol_q;
      mosi_out_q <= mosi_d;
      busy_out_q <= active_d;
      done_out_q <= done;
      rx_out_q   <= rx_res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sck_level_o  = sck_out_q;
  assign mosi_level_o = mosi_out_q;
  assign busy_res_o   = busy_out_q;
  assign done_res_o   = done_out_q;
  assign rx_data_o    = rx_out_q;

endmodule

@@ rtl/core/spise_checker.sv @@
`include "spi_master_shift_engine_defines.svh"

module spise_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic                             busy_res_o,
  input logic                             done_res_o,
  input logic [spise_pkg::WORD_W-1:0]     rx_data_o
);

  // a stalled result item holds
  `SPISE_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(rx_data_o))

  // an empty output register never blocks intake
  `SPISE_ASSERT(a_ready_when_empty, !out_valid_o |-> in_ready_o)

  // an accepted item always yields a result next cycle
  `SPISE_ASSERT(a_item_yields_result, in_valid_i && in_ready_o |=> out_valid_o)

  // finishing a transfer leaves the engine idle with the clock at rest
  `SPISE_ASSERT(a_done_idle, out_valid_o && done_res_o |-> !busy_res_o)

  // received word is shown only on the finishing item
  `SPISE_ASSERT(a_rx_only_on_done, out_valid_o && !done_res_o |-> rx_data_o == '0)

endmodule

bind spi_master_shift_engine spise_checker u_spise_checker (.*);
